[rtl/kdp_pkg.sv]
// Package with the shared types and constants of the key debounce and pin timer table.
package kdp_pkg;

  localparam int ENTRIES    = 16;
  localparam int AW         = $clog2(ENTRIES);
  localparam int PW         = $clog2(ENTRIES + 1);
  localparam int RESULT_CAP = 16;
  localparam int CW         = $clog2(RESULT_CAP + 1);

  localparam logic [2:0] CMD_EDGE   = 3'd0;
  localparam logic [2:0] CMD_PTICK  = 3'd1;
  localparam logic [2:0] CMD_TSTART = 3'd2;
  localparam logic [2:0] CMD_TCLEAR = 3'd3;
  localparam logic [2:0] CMD_TTICK  = 3'd4;

  localparam logic [3:0] PC_DOWN  = 4'd0;
  localparam logic [3:0] PC_UP    = 4'd1;
  localparam logic [3:0] PC_QUICK = 4'd2;
  localparam logic [3:0] PC_LONG  = 4'd3;

  localparam logic [2:0] REG_DEBOUNCE = 3'd0;
  localparam logic [2:0] REG_QUICK    = 3'd1;
  localparam logic [2:0] REG_LONG     = 3'd2;
  localparam logic [2:0] REG_REPEAT   = 3'd3;
  localparam logic [2:0] REG_OTIMER   = 3'd4;

  typedef struct packed {
    logic [7:0]  pin;
    logic [3:0]  code;
    logic [15:0] rem;
  } entry_t;

  typedef struct packed {
    logic       push;
    logic       flush;
    logic       kind;
    logic [7:0] pin;
    logic [3:0] code;
  } ob_req_t;

  typedef struct packed {
    logic push_ok;
    logic flush_ok;
  } ob_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_EX, S_FIN, S_JRD, S_JEX, S_TRIMP, S_TRIMT, S_DONE
  } state_e;

endpackage

[rtl/key_debounce_press_timer_table_core.sv]
// Top level: command sequencer that scans the shared press and timer table.
// Each request reads and then examines each table entry that it scans, then finishes; each up
// release adds a scan of the press region, and each region trim pulls back one slot at a time.
// A result waits one place back until the next is found or the request ends; a full output stalls.
// Reset clears the busy bits and region bounds at once; no clearing pass is needed.
module key_debounce_press_timer_table_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // pin_number[7:0], code[11:8], zero[15:12]
  input  logic [2:0]  s_axis_tuser,  // command[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // out_pin[7:0], out_code[11:8], zero[15:12]
  output logic        m_axis_tuser,  // kind[0]
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [kdp_pkg::PW-1:0] NENT = kdp_pkg::PW'(kdp_pkg::ENTRIES);

  kdp_pkg::state_e state_q, state_d, ret_q, ret_d;
  logic [2:0]              cmd_q, cmd_d;
  logic [7:0]              pin_q, pin_d, ipin_q, ipin_d;
  logic [3:0]              code_q, code_d;
  logic [kdp_pkg::PW-1:0]  idx_q, idx_d, j_q, j_d, ptop_q, ptop_d, tbot_q, tbot_d;
  logic                    fnd_q, fnd_d;
  logic [kdp_pkg::AW-1:0]  fidx_q, fidx_d;
  logic [kdp_pkg::CW-1:0]  cnt_q, cnt_d;
  logic [kdp_pkg::ENTRIES-1:0] busy_q;
  logic [15:0] dbt_q, qt_q, lt_q, rt_q, ot_q, cfg_v;

  logic                    we;
  logic [kdp_pkg::AW-1:0]  waddr, raddr;
  kdp_pkg::entry_t         wdata, rd;
  kdp_pkg::ob_req_t        ob_req;
  kdp_pkg::ob_rsp_t        ob_rsp;

  logic        em_v, em_kind, eff, stall, rbusy, is_timer;
  logic [7:0]  em_pin;
  logic [3:0]  em_code, st;
  logic [15:0] dec;
  logic [kdp_pkg::PW-1:0] idx_n, j_n, pm1;

  kdp_table u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  kdp_outbuf u_outbuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (ob_req),
    .rsp_o         (ob_rsp),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  assign cfg_v = (cfg_data_i == 16'd0) ? 16'd1 : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbt_q <= 16'd20;
      qt_q  <= 16'd30;
      lt_q  <= 16'd100;
      rt_q  <= 16'd20;
      ot_q  <= 16'd100;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kdp_pkg::REG_DEBOUNCE: dbt_q <= cfg_v;
        kdp_pkg::REG_QUICK:    qt_q  <= cfg_v;
        kdp_pkg::REG_LONG:     lt_q  <= cfg_v;
        kdp_pkg::REG_REPEAT:   rt_q  <= cfg_v;
        kdp_pkg::REG_OTIMER:   ot_q  <= cfg_v;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kdp_pkg::S_IDLE;
      ret_q   <= kdp_pkg::S_RD;
      cmd_q   <= kdp_pkg::CMD_EDGE;
      idx_q   <= '0;
      j_q     <= '0;
      ptop_q  <= '0;
      tbot_q  <= NENT;
      fnd_q   <= 1'b0;
      fidx_q  <= '0;
      cnt_q   <= '0;
      busy_q  <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cmd_q   <= cmd_d;
      idx_q   <= idx_d;
      j_q     <= j_d;
      ptop_q  <= ptop_d;
      tbot_q  <= tbot_d;
      fnd_q   <= fnd_d;
      fidx_q  <= fidx_d;
      cnt_q   <= cnt_d;
      if (we) begin
        busy_q[waddr] <= (wdata.rem != 16'd0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pin_q  <= pin_d;
    code_q <= code_d;
    ipin_q <= ipin_d;
  end

  assign raddr = (state_q == kdp_pkg::S_JRD || state_q == kdp_pkg::S_JEX) ?
                 j_q[kdp_pkg::AW-1:0] : idx_q[kdp_pkg::AW-1:0];
  assign rbusy = (rd.rem != 16'd0);
  assign dec   = rd.rem - 16'd1;
  assign idx_n = idx_q + kdp_pkg::PW'(1);
  assign j_n   = j_q + kdp_pkg::PW'(1);
  assign pm1   = ptop_q - kdp_pkg::PW'(1);
  assign is_timer = (cmd_q == kdp_pkg::CMD_TSTART) || (cmd_q == kdp_pkg::CMD_TCLEAR) ||
                    (cmd_q == kdp_pkg::CMD_TTICK);
  assign st = (code_q == 4'd0) ? kdp_pkg::PC_DOWN : kdp_pkg::PC_UP;

  always_comb begin
    em_v    = 1'b0;
    em_kind = 1'b0;
    em_pin  = rd.pin;
    em_code = rd.code;
    case (state_q)
      kdp_pkg::S_EX: begin
        if (cmd_q == kdp_pkg::CMD_TTICK) begin
          em_v    = rbusy && (dec == 16'd0);
          em_kind = 1'b1;
        end else if (cmd_q == kdp_pkg::CMD_PTICK) begin
          em_v = rbusy && (dec == 16'd0) && (rd.code != kdp_pkg::PC_UP) &&
                 (rd.code != kdp_pkg::PC_QUICK);
          em_code = (rd.code == kdp_pkg::PC_DOWN) ? kdp_pkg::PC_DOWN : kdp_pkg::PC_LONG;
        end
      end
      kdp_pkg::S_JRD: begin
        em_v    = (j_q >= ptop_q);
        em_pin  = ipin_q;
        em_code = kdp_pkg::PC_UP;
      end
      kdp_pkg::S_JEX: begin
        em_v = (j_q != idx_q) && rbusy && (rd.pin == ipin_q);
      end
      default: ;
    endcase
  end

  assign eff   = em_v && (cnt_q < kdp_pkg::CW'(kdp_pkg::RESULT_CAP));
  assign stall = eff && !ob_rsp.push_ok;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    cmd_d   = cmd_q;
    pin_d   = pin_q;
    code_d  = code_q;
    ipin_d  = ipin_q;
    idx_d   = idx_q;
    j_d     = j_q;
    ptop_d  = ptop_q;
    tbot_d  = tbot_q;
    fnd_d   = fnd_q;
    fidx_d  = fidx_q;
    cnt_d   = (eff && ob_rsp.push_ok) ? cnt_q + kdp_pkg::CW'(1) : cnt_q;
    we      = 1'b0;
    waddr   = idx_q[kdp_pkg::AW-1:0];
    wdata   = '0;
    ob_req        = '0;
    ob_req.push   = eff;
    ob_req.kind   = em_kind;
    ob_req.pin    = em_pin;
    ob_req.code   = em_code;
    s_axis_tready = (state_q == kdp_pkg::S_IDLE);

    case (state_q)
      kdp_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d  = s_axis_tuser;
          pin_d  = s_axis_tdata[7:0];
          code_d = s_axis_tdata[11:8];
          fnd_d  = 1'b0;
          cnt_d  = '0;
          if (s_axis_tuser == kdp_pkg::CMD_TSTART || s_axis_tuser == kdp_pkg::CMD_TCLEAR ||
              s_axis_tuser == kdp_pkg::CMD_TTICK) begin
            idx_d   = tbot_q;
            state_d = kdp_pkg::S_RD;
          end else if (s_axis_tuser == kdp_pkg::CMD_EDGE ||
                       s_axis_tuser == kdp_pkg::CMD_PTICK) begin
            idx_d   = '0;
            state_d = kdp_pkg::S_RD;
          end else begin
            state_d = kdp_pkg::S_DONE;
          end
        end
      end
      kdp_pkg::S_RD: begin
        if ((is_timer && idx_q >= NENT) || (!is_timer && idx_q >= ptop_q)) begin
          if (cmd_q == kdp_pkg::CMD_EDGE || cmd_q == kdp_pkg::CMD_TSTART) begin
            state_d = kdp_pkg::S_FIN;
          end else begin
            state_d = kdp_pkg::S_DONE;
          end
        end else begin
          state_d = kdp_pkg::S_EX;
        end
      end
      kdp_pkg::S_EX: begin
        case (cmd_q)
          kdp_pkg::CMD_EDGE, kdp_pkg::CMD_TSTART: begin
            if (rbusy && rd.pin == pin_q &&
                (cmd_q == kdp_pkg::CMD_TSTART ||
                 rd.code == kdp_pkg::PC_DOWN || rd.code == kdp_pkg::PC_UP)) begin
              we      = 1'b1;
              wdata   = '{pin: rd.pin, code: rd.code,
                          rem: (cmd_q == kdp_pkg::CMD_EDGE) ? dbt_q : ot_q};
              state_d = kdp_pkg::S_DONE;
            end else begin
              if (!rbusy && !fnd_q) begin
                fnd_d  = 1'b1;
                fidx_d = idx_q[kdp_pkg::AW-1:0];
              end
              idx_d   = idx_n;
              state_d = kdp_pkg::S_RD;
            end
          end
          kdp_pkg::CMD_TCLEAR, kdp_pkg::CMD_TTICK: begin
            if (!stall) begin
              idx_d   = idx_n;
              state_d = kdp_pkg::S_RD;
              if (rbusy && ((cmd_q == kdp_pkg::CMD_TCLEAR && rd.pin == pin_q) ||
                            (cmd_q == kdp_pkg::CMD_TTICK && dec == 16'd0))) begin
                we = 1'b1;
                if (idx_q == tbot_q) begin
                  ret_d   = kdp_pkg::S_RD;
                  state_d = kdp_pkg::S_TRIMT;
                end
              end else if (rbusy && cmd_q == kdp_pkg::CMD_TTICK) begin
                we    = 1'b1;
                wdata = '{pin: rd.pin, code: rd.code, rem: dec};
              end
            end
          end
          default: begin
            if (!rbusy) begin
              idx_d   = idx_n;
              state_d = kdp_pkg::S_RD;
            end else if (dec != 16'd0) begin
              we      = 1'b1;
              wdata   = '{pin: rd.pin, code: rd.code, rem: dec};
              idx_d   = idx_n;
              state_d = kdp_pkg::S_RD;
            end else if (!stall) begin
              we      = 1'b1;
              idx_d   = idx_n;
              state_d = kdp_pkg::S_RD;
              case (rd.code)
                kdp_pkg::PC_UP: begin
                  wdata   = '{pin: rd.pin, code: rd.code, rem: 16'd0};
                  ipin_d  = rd.pin;
                  j_d     = '0;
                  idx_d   = idx_q;
                  state_d = kdp_pkg::S_JRD;
                end
                kdp_pkg::PC_DOWN:  wdata = '{pin: rd.pin, code: kdp_pkg::PC_QUICK, rem: qt_q};
                kdp_pkg::PC_QUICK: wdata = '{pin: rd.pin, code: kdp_pkg::PC_LONG, rem: lt_q};
                default:           wdata = '{pin: rd.pin, code: rd.code, rem: rt_q};
              endcase
            end
          end
        endcase
      end
      kdp_pkg::S_JRD: begin
        if (j_q >= ptop_q) begin
          if (!stall) begin
            we      = 1'b1;
            idx_d   = idx_n;
            state_d = kdp_pkg::S_RD;
            if (idx_n == ptop_q) begin
              ret_d   = kdp_pkg::S_RD;
              state_d = kdp_pkg::S_TRIMP;
            end
          end
        end else begin
          state_d = kdp_pkg::S_JEX;
        end
      end
      kdp_pkg::S_JEX: begin
        waddr = j_q[kdp_pkg::AW-1:0];
        if (!stall) begin
          j_d     = j_n;
          state_d = kdp_pkg::S_JRD;
          if (em_v) begin
            we = 1'b1;
            if (j_n == ptop_q) begin
              ret_d   = kdp_pkg::S_JRD;
              state_d = kdp_pkg::S_TRIMP;
            end
          end
        end
      end
      kdp_pkg::S_FIN: begin
        state_d = kdp_pkg::S_DONE;
        wdata   = '{pin: pin_q,
                    code: (cmd_q == kdp_pkg::CMD_EDGE) ? st : code_q,
                    rem: (cmd_q == kdp_pkg::CMD_EDGE) ? dbt_q : ot_q};
        if (fnd_q) begin
          we    = 1'b1;
          waddr = fidx_q;
        end else if (ptop_q < tbot_q) begin
          we = 1'b1;
          if (cmd_q == kdp_pkg::CMD_EDGE) begin
            waddr  = ptop_q[kdp_pkg::AW-1:0];
            ptop_d = ptop_q + kdp_pkg::PW'(1);
          end else begin
            tbot_d = tbot_q - kdp_pkg::PW'(1);
            waddr  = tbot_d[kdp_pkg::AW-1:0];
          end
        end
      end
      kdp_pkg::S_TRIMP: begin
        if (ptop_q != '0 && !busy_q[pm1[kdp_pkg::AW-1:0]]) begin
          ptop_d = pm1;
        end else begin
          state_d = ret_q;
        end
      end
      kdp_pkg::S_TRIMT: begin
        if (tbot_q != NENT && !busy_q[tbot_q[kdp_pkg::AW-1:0]]) begin
          tbot_d = tbot_q + kdp_pkg::PW'(1);
        end else begin
          state_d = ret_q;
        end
      end
      kdp_pkg::S_DONE: begin
        ob_req.flush = 1'b1;
        if (ob_rsp.flush_ok) begin
          state_d = kdp_pkg::S_IDLE;
        end
      end
      default: state_d = kdp_pkg::S_IDLE;
    endcase
  end

endmodule

[rtl/kdp_table.sv]
// Entry table memory with one write port and a registered read port.
module kdp_table (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [kdp_pkg::AW-1:0]  waddr_i,
  input  kdp_pkg::entry_t         wdata_i,
  input  logic [kdp_pkg::AW-1:0]  raddr_i,
  output kdp_pkg::entry_t         rdata_o
);

  kdp_pkg::entry_t mem_q [kdp_pkg::ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/kdp_outbuf.sv]
// Result buffer that holds one result back so the final one can be marked last.
module kdp_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kdp_pkg::ob_req_t  req_i,
  output kdp_pkg::ob_rsp_t  rsp_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,  // out_pin[7:0], out_code[11:8], zero[15:12]
  output logic              m_axis_tuser,  // kind[0]
  output logic              m_axis_tlast
);

  logic       pend_v_q;
  logic       pend_kind_q;
  logic [7:0] pend_pin_q;
  logic [3:0] pend_code_q;
  logic       out_v_q;
  logic       out_kind_q;
  logic [7:0] out_pin_q;
  logic [3:0] out_code_q;
  logic       out_last_q;
  logic       out_free;
  logic       do_push;
  logic       do_flush;
  logic       move;

  assign out_free = !out_v_q || m_axis_tready;
  assign rsp_o.push_ok = !pend_v_q || out_free;
  assign rsp_o.flush_ok = !pend_v_q || out_free;
  assign do_push = req_i.push && rsp_o.push_ok;
  assign do_flush = req_i.flush && pend_v_q && out_free;
  assign move = (do_push && pend_v_q) || do_flush;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (do_push) begin
        pend_v_q <= 1'b1;
      end else if (do_flush) begin
        pend_v_q <= 1'b0;
      end
      if (move) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_kind_q <= pend_kind_q;
      out_pin_q  <= pend_pin_q;
      out_code_q <= pend_code_q;
      out_last_q <= do_flush;
    end
    if (do_push) begin
      pend_kind_q <= req_i.kind;
      pend_pin_q  <= req_i.pin;
      pend_code_q <= req_i.code;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {4'd0, out_code_q, out_pin_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule
